@@ rtl/acm_pkg.sv @@
// shared types, constants and state codes of the covariance model core
`timescale 1ns / 1ps
package acm_pkg;

	// table geometry
	localparam int MAX_STRUCTURES   = 4;
	localparam int WORDS_PER_STRUCT = 11;
	localparam int TABLE_DEPTH      = MAX_STRUCTURES * WORDS_PER_STRUCT;
	localparam int ADDR_W           = $clog2(TABLE_DEPTH);
	localparam int PADDR_W          = 3;
	localparam int DIV_ITERS_W      = 7;

	// word positions inside one structure
	localparam logic [3:0] WORD_LAST_COEF = 4'd8;
	localparam logic [3:0] WORD_SILL      = 4'd9;
	localparam logic [3:0] WORD_RANGE     = 4'd10;
	localparam logic [3:0] WORD_TYPE      = 4'd11;

	// exponential series
	localparam logic [30:0] LN2_Q30      = 31'd744261118;
	localparam logic [3:0]  TAYLOR_TERMS = 4'd12;

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// model types
	localparam logic [1:0] MODEL_SPH     = 2'd0;
	localparam logic [1:0] MODEL_EXP     = 2'd1;
	localparam logic [1:0] MODEL_GAU     = 2'd2;
	localparam logic [1:0] MODEL_UNKNOWN = 2'd3;

	// register indexes
	localparam logic REG_NST    = 1'b0;
	localparam logic REG_NUGGET = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [1:0]         structure_index;
		logic [3:0]         word_index;
		logic signed [31:0] load_value;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic signed [31:0] offset_z;
	} req_t;

	typedef struct packed {
		logic [30:0] covariance;
		logic        zero_lag;
		logic        unknown_model;
	} rsp_t;

	typedef struct packed {
		logic                   start;
		logic [DIV_ITERS_W-1:0] iters;
	} div_req_t;

	typedef enum logic [4:0] {
		S_IDLE, S_STRUCT, S_SILL, S_RANGE,
		S_COEF_RD, S_COEF_MUL, S_COEF_ACC, S_SQ_MUL, S_SQ_ACC,
		S_SQRT, S_HR_GO, S_HR_DIV, S_SHAPE,
		S_SPH1, S_SPH2, S_SPH3, S_GAU1, S_GAU2,
		S_EXP_START, S_EXP_NDIV, S_EXP_MUL, S_EXP_TGO, S_EXP_TDIV, S_EXP_FIN,
		S_CONTRIB, S_CONTRIB_ACC, S_NEXT, S_DONE
	} acm_state_t;

endpackage

@@ rtl/acm_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module acm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  acm_pkg::div_req_t div_req,
	input  logic [63:0]       dividend,
	input  logic [30:0]       divisor,
	output logic              done,
	output logic [63:0]       quotient
);
	import acm_pkg::*;

	logic [63:0]            num_q;
	logic [63:0]            quo_q;
	logic [30:0]            rem_q;
	logic [30:0]            dvs_q;
	logic [DIV_ITERS_W-1:0] cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [31:0]            rem_sh;
	logic [31:0]            rem_sub;
	logic                   ge;

	// one trial subtraction
	assign rem_sh  = {rem_q, num_q[63]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign ge      = rem_sh >= {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (div_req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= div_req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_ITERS_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (div_req.start) begin
			num_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			rem_q <= ge ? rem_sub[30:0] : rem_sh[30:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/anisotropic_covariance_model_core.sv @@
// nested anisotropic covariance model core
// a load item is written as it is accepted; an evaluate item runs, per structure in use,
// sill and range reads and, away from zero lag, rotation, square root, range division
// and shape on the shared multiplier, divider and range-reduction loop
// throughput: one evaluate item at a time; the next is taken once its result is registered
// reset: state, config registers, output valid clear; tables and datapath have no reset
`timescale 1ns / 1ps
module anisotropic_covariance_model_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  acm_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output acm_pkg::rsp_t                 rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [acm_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import acm_pkg::*;

	acm_state_t state_q, state_d;

	// configuration
	logic [2:0]  nst_q;
	logic [30:0] nugget_q;
	logic [2:0]  nst_eff;
	logic        reg_idx;

	// tables
	logic signed [31:0] coef_mem [TABLE_DEPTH];
	logic [1:0]         type_tab [MAX_STRUCTURES];
	logic signed [31:0] rdata_q;
	logic [ADDR_W-1:0]  raddr, waddr, base;
	logic               mem_we, type_we, accept;
	logic [1:0]         type_cur;

	// item and sequencing state
	logic signed [31:0] dx_q, dy_q, dz_q, d_sel;
	logic               zero_q, unknown_q;
	logic [2:0]         s_q;
	logic signed [35:0] cov_q;
	logic signed [31:0] sill_q;
	logic [30:0]        range_q;
	logic [3:0]         w_q;
	logic [1:0]         j_q;
	logic signed [41:0] t_q, t_new, t_abs;
	logic [30:0]        a_q, a_clamp;
	logic [63:0]        sq_q, sq_new;
	logic [63:0]        v_q, res_q, bit_q, trial;
	logic               sq_ge;
	logic [4:0]         cnt_q;
	logic [61:0]        hr_q;
	logic [34:0]        x_q;
	logic [5:0]         n_q;
	logic [29:0]        r_q;
	logic [30:0]        term_q;
	logic signed [32:0] sum_q;
	logic [3:0]         k_q;
	logic [30:0]        shape_q;

	// shape helpers
	logic [63:0]        hr3;
	logic               exp_over;
	logic               exp_ge;
	logic [33:0]        g;
	logic [35:0]        g3;
	logic [33:0]        three_hr;
	logic signed [33:0] sph_v;
	logic [30:0]        sph_shape, exp_shape, cov_sat;

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p, prod_q;

	// divider
	div_req_t    div_req;
	logic [63:0] div_dividend, div_quo;
	logic [30:0] div_divisor;
	logic        div_done;

	// output register
	logic rsp_valid_q, out_free;
	rsp_t rsp_q;

	acm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.div_req   (div_req),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo)
	);

	// configuration port
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_NST) ? {29'd0, nst_q} : {1'b0, nugget_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nst_q    <= '0;
			nugget_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_NST:    nst_q    <= pwdata[2:0];
				REG_NUGGET: nugget_q <= pwdata[30:0];
				default:    ;
			endcase
		end
	end

	assign nst_eff = (nst_q > 3'(MAX_STRUCTURES)) ? 3'(MAX_STRUCTURES) : nst_q;

	// table access
	assign accept   = req_valid && req_ready;
	assign mem_we   = accept && (req.operation == OP_LOAD) &&
	                  (req.word_index < 4'(WORDS_PER_STRUCT));
	assign type_we  = accept && (req.operation == OP_LOAD) && (req.word_index == WORD_TYPE);
	assign waddr    = ADDR_W'(req.structure_index * WORDS_PER_STRUCT) + ADDR_W'(req.word_index);
	assign base     = ADDR_W'(s_q[1:0] * WORDS_PER_STRUCT);
	assign type_cur = type_tab[s_q[1:0]];

	always_ff @(posedge clk) begin
		if (mem_we)
			coef_mem[waddr] <= req.load_value;
		rdata_q <= coef_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (type_we)
			type_tab[req.structure_index] <= req.load_value[1:0];
	end

	// multiplier with registered product
	assign mul_p = mul_a * mul_b;
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
	end

	// lag component for the current column
	always_comb begin
		case (j_q)
			2'd0:    d_sel = dx_q;
			2'd1:    d_sel = dy_q;
			default: d_sel = dz_q;
		endcase
	end

	// rotated component accumulate and clamp
	assign t_new   = t_q + 42'(signed'(prod_q[63:24]));
	assign t_abs   = t_new[41] ? -t_new : t_new;
	assign a_clamp = (t_abs > 42'sd2147483647) ? 31'h7FFFFFFF : t_abs[30:0];
	assign sq_new  = sq_q + prod_q[63:0];

	// square root step
	assign trial = res_q + bit_q;
	assign sq_ge = v_q >= trial;

	// shape helpers
	assign hr3       = ({2'b00, hr_q} << 1) + {2'b00, hr_q};
	assign exp_over  = hr3[63:35] != '0;
	assign exp_ge    = x_q >= {4'd0, LN2_Q30};
	assign g         = prod_q[63:30];
	assign g3        = {1'b0, g, 1'b0} + {2'b00, g};
	assign three_hr  = {3'b000, hr_q[29:0], 1'b0} + {4'b0000, hr_q[29:0]};
	assign sph_v     = 34'sh080000000 - $signed(three_hr) + $signed({4'b0000, prod_q[59:30]});
	assign sph_shape = sph_v[33] ? '0 : sph_v[31:1];
	assign exp_shape = (sum_q[32] || (n_q > 6'd30)) ? '0 : (sum_q[30:0] >> n_q);

	// result saturation
	assign cov_sat = cov_q[35] ? '0 :
	                 ((cov_q > 36'sh07FFFFFFF) ? 31'h7FFFFFFF : cov_q[30:0]);
	assign out_free = !rsp_valid_q || rsp_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:
				if (accept && (req.operation == OP_EVAL))
					state_d = S_STRUCT;
			S_STRUCT:      state_d = (s_q >= nst_eff) ? S_DONE : S_SILL;
			S_SILL:        state_d = S_RANGE;
			S_RANGE:
				if (zero_q || (type_cur == MODEL_UNKNOWN) || (rdata_q <= 0))
					state_d = S_NEXT;
				else
					state_d = S_COEF_RD;
			S_COEF_RD:     state_d = S_COEF_MUL;
			S_COEF_MUL:    state_d = S_COEF_ACC;
			S_COEF_ACC:    state_d = (j_q == 2'd2) ? S_SQ_MUL : S_COEF_RD;
			S_SQ_MUL:      state_d = S_SQ_ACC;
			S_SQ_ACC:      state_d = (w_q == WORD_LAST_COEF) ? S_SQRT : S_COEF_RD;
			S_SQRT:        state_d = (cnt_q == 5'd31) ? S_HR_GO : S_SQRT;
			S_HR_GO:       state_d = S_HR_DIV;
			S_HR_DIV:      state_d = div_done ? S_SHAPE : S_HR_DIV;
			S_SHAPE: begin
				case (type_cur)
					MODEL_SPH: state_d = (hr_q[61:30] != '0) ? S_CONTRIB : S_SPH1;
					MODEL_EXP: state_d = exp_over ? S_CONTRIB : S_EXP_START;
					MODEL_GAU: state_d = (hr_q[61:32] != '0) ? S_CONTRIB : S_GAU1;
					default:   state_d = S_CONTRIB;
				endcase
			end
			S_SPH1:        state_d = S_SPH2;
			S_SPH2:        state_d = S_SPH3;
			S_SPH3:        state_d = S_CONTRIB;
			S_GAU1:        state_d = S_GAU2;
			S_GAU2:        state_d = g3[35] ? S_CONTRIB : S_EXP_START;
			S_EXP_START:   state_d = S_EXP_NDIV;
			S_EXP_NDIV:    state_d = exp_ge ? S_EXP_NDIV : S_EXP_MUL;
			S_EXP_MUL:     state_d = S_EXP_TGO;
			S_EXP_TGO:     state_d = S_EXP_TDIV;
			S_EXP_TDIV:
				if (div_done)
					state_d = (k_q == TAYLOR_TERMS) ? S_EXP_FIN : S_EXP_MUL;
			S_EXP_FIN:     state_d = S_CONTRIB;
			S_CONTRIB:     state_d = S_CONTRIB_ACC;
			S_CONTRIB_ACC: state_d = S_NEXT;
			S_NEXT:        state_d = S_STRUCT;
			S_DONE:        state_d = out_free ? S_IDLE : S_DONE;
			default:       state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// sequencer outputs: handshake, table address, multiplier and divider operands
	always_comb begin
		req_ready    = 1'b0;
		raddr        = base;
		mul_a        = '0;
		mul_b        = '0;
		div_req      = '0;
		div_dividend = '0;
		div_divisor  = '0;
		unique case (state_q)
			S_IDLE:    req_ready = 1'b1;
			S_STRUCT:  raddr = base + ADDR_W'(WORD_SILL);
			S_SILL:    raddr = base + ADDR_W'(WORD_RANGE);
			S_COEF_RD: raddr = base + ADDR_W'(w_q);
			S_COEF_MUL: begin
				mul_a = 33'(rdata_q);
				mul_b = 33'(d_sel);
			end
			S_SQ_MUL: begin
				mul_a = {2'b00, a_q};
				mul_b = {2'b00, a_q};
			end
			S_HR_GO: begin
				div_req.start = 1'b1;
				div_req.iters = DIV_ITERS_W'(62);
				div_dividend  = {res_q[31:0], 32'd0};
				div_divisor   = range_q;
			end
			S_SPH1: begin
				mul_a = {3'b000, hr_q[29:0]};
				mul_b = {3'b000, hr_q[29:0]};
			end
			S_SPH2: begin
				mul_a = {3'b000, prod_q[59:30]};
				mul_b = {3'b000, hr_q[29:0]};
			end
			S_GAU1: begin
				mul_a = {1'b0, hr_q[31:0]};
				mul_b = {1'b0, hr_q[31:0]};
			end
			S_EXP_MUL: begin
				mul_a = {2'b00, term_q};
				mul_b = {3'b000, r_q};
			end
			S_EXP_TGO: begin
				div_req.start = 1'b1;
				div_req.iters = DIV_ITERS_W'(30);
				div_dividend  = {prod_q[59:30], 34'd0};
				div_divisor   = {27'd0, k_q};
			end
			S_CONTRIB: begin
				mul_a = 33'(sill_q);
				mul_b = {2'b00, shape_q};
			end
			default: ;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept && (req.operation == OP_EVAL)) begin
					dx_q      <= req.offset_x;
					dy_q      <= req.offset_y;
					dz_q      <= req.offset_z;
					zero_q    <= (req.offset_x == 0) && (req.offset_y == 0) &&
					             (req.offset_z == 0);
					s_q       <= '0;
					unknown_q <= 1'b0;
					if ((req.offset_x == 0) && (req.offset_y == 0) && (req.offset_z == 0))
						cov_q <= {5'd0, nugget_q};
					else
						cov_q <= '0;
				end
			end
			S_STRUCT: begin
				if ((s_q < nst_eff) && (type_cur == MODEL_UNKNOWN))
					unknown_q <= 1'b1;
			end
			S_SILL: sill_q <= rdata_q;
			S_RANGE: begin
				range_q <= rdata_q[30:0];
				if (zero_q)
					cov_q <= cov_q + 36'(sill_q);
				w_q  <= '0;
				j_q  <= '0;
				t_q  <= '0;
				sq_q <= '0;
			end
			S_COEF_ACC: begin
				if (j_q == 2'd2) begin
					t_q <= '0;
					a_q <= a_clamp;
				end else begin
					t_q <= t_new;
					j_q <= j_q + 2'd1;
					w_q <= w_q + 4'd1;
				end
			end
			S_SQ_ACC: begin
				sq_q <= sq_new;
				if (w_q == WORD_LAST_COEF) begin
					v_q   <= sq_new;
					res_q <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
					cnt_q <= '0;
				end else begin
					w_q <= w_q + 4'd1;
					j_q <= '0;
				end
			end
			S_SQRT: begin
				if (sq_ge) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 5'd1;
			end
			S_HR_DIV: begin
				if (div_done)
					hr_q <= div_quo[61:0];
			end
			S_SHAPE: begin
				case (type_cur)
					MODEL_SPH: if (hr_q[61:30] != '0) shape_q <= '0;
					MODEL_EXP: begin
						if (exp_over)
							shape_q <= '0;
						else
							x_q <= hr3[34:0];
					end
					MODEL_GAU: if (hr_q[61:32] != '0) shape_q <= '0;
					default:   shape_q <= '0;
				endcase
			end
			S_SPH3: shape_q <= sph_shape;
			S_GAU2: begin
				if (g3[35])
					shape_q <= '0;
				else
					x_q <= g3[34:0];
			end
			S_EXP_START: n_q <= '0;
			// range reduction: subtract ln2 until the remainder is below it
			S_EXP_NDIV: begin
				if (exp_ge) begin
					x_q <= x_q - {4'd0, LN2_Q30};
					n_q <= n_q + 6'd1;
				end else begin
					r_q    <= x_q[29:0];
					term_q <= 31'h4000_0000;
					sum_q  <= 33'sh0_4000_0000;
					k_q    <= 4'd1;
				end
			end
			S_EXP_TDIV: begin
				if (div_done) begin
					term_q <= {1'b0, div_quo[29:0]};
					if (k_q[0])
						sum_q <= sum_q - $signed({3'b000, div_quo[29:0]});
					else
						sum_q <= sum_q + $signed({3'b000, div_quo[29:0]});
					if (k_q != TAYLOR_TERMS)
						k_q <= k_q + 4'd1;
				end
			end
			S_EXP_FIN:     shape_q <= exp_shape;
			S_CONTRIB_ACC: cov_q   <= cov_q + 36'(signed'(prod_q[63:30]));
			S_NEXT:        s_q     <= s_q + 3'd1;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if ((state_q == S_DONE) && out_free)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			rsp_q.covariance    <= cov_sat;
			rsp_q.zero_lag      <= zero_q;
			rsp_q.unknown_model <= unknown_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/acm_checker.sv @@
// port-level checks of the covariance model core and their binding
`timescale 1ns / 1ps
module acm_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input acm_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input acm_pkg::rsp_t rsp
);
	import acm_pkg::*;

	// a pending result holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// an evaluate item makes the block busy
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.operation == OP_EVAL) |=> !req_ready)
		else $error("ready after evaluate item");

	// a load item keeps the block ready
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.operation == OP_LOAD) |=> req_ready)
		else $error("busy after load item");

	// a new result comes only out of a busy phase
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result without evaluation");

endmodule

bind anisotropic_covariance_model_core acm_checker u_acm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
